@@ rtl/bst_pkg.sv @@
// Package for the array binary search tree insert unit.
// Holds the sequencer state type, response status codes and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

   localparam int VALUE_W = 16;
   localparam int CODE_W  = 17;
   localparam int SLOT_W  = 7;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_READ   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_ZERO     = 2'd2,
      STATUS_READ     = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_READ   = 5'b00100,
      ST_WALK   = 5'b01000,
      ST_REJECT = 5'b10000
   } state_type;

endpackage

`default_nettype wire

@@ rtl/bst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Read data holds until the next read enable. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bst_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 128
) (
   input  wire                                  clock,
   input  wire                                  wr_en,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire [WIDTH-1:0]                      wr_data,
   input  wire                                  rd_en,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/array_bst_insert_unit.sv @@
// Array binary search tree insert unit: insert walks one tree level per RAM read.
// A read passes through ST_READ and a zero value through ST_REJECT; an insert reads the root
// first and then one child per level until it finds an empty slot or walks off the table.
// One request in flight; the next is taken in the cycle in which the result appears at
// the output, and a held result stalls the walk. Reset: synchronous, active high, then
// a clearing pass that zeroes every tree RAM entry, with req_ready low.
`timescale 1ns / 1ps
`default_nettype none

module array_bst_insert_unit #(
   parameter int TABLE_SLOTS = 128
) (
   input  wire                              clock,
   input  wire                              reset,

   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire                              req_op,
   input  wire signed [bst_pkg::VALUE_W-1:0] req_value,
   input  wire [bst_pkg::SLOT_W-1:0]        req_slot,

   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic [bst_pkg::SLOT_W-1:0]       rsp_placed_slot,
   output logic signed [bst_pkg::CODE_W-1:0] rsp_stored_code,
   output logic signed [bst_pkg::VALUE_W-1:0] rsp_decoded_value,
   output logic                             rsp_occupied
);

   // RAM address width and walk index width; the index must reach 2*TABLE_SLOTS-1
   // and also hold any request slot number.
   localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int IW = (AW + 1 > bst_pkg::SLOT_W) ? AW + 1 : bst_pkg::SLOT_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_SLOTS - 1);
   localparam logic [IW-1:0] SLOTS_IW  = IW'(TABLE_SLOTS);
   localparam logic [IW-1:0] ROOT_IDX  = IW'(1);

   bst_pkg::state_type state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [IW-1:0]      j_ff, j_in;
   logic signed [bst_pkg::CODE_W-1:0] code_ff, code_in;
   logic [bst_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic               inrange_ff, inrange_in;

   logic               rsp_valid_ff, rsp_valid_in;
   bst_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [bst_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic signed [bst_pkg::CODE_W-1:0] rsp_code_ff, rsp_code_in;

   // RAM port signals
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [bst_pkg::CODE_W-1:0] ram_wdata;
   logic               ram_re;
   logic [AW-1:0]      ram_raddr;
   logic [bst_pkg::CODE_W-1:0] ram_rdata;

   logic               out_free;
   logic [IW-1:0]      j_next;
   logic [IW-1:0]      slot_ext;
   logic               go_right;

   bst_ram #(
      .WIDTH (bst_pkg::CODE_W),
      .DEPTH (TABLE_SLOTS)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Result register can take a new result when empty or draining this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign slot_ext = IW'(req_slot);
   // Go right when the new code is strictly greater than the stored one.
   assign go_right = code_ff > $signed(ram_rdata);
   assign j_next   = {j_ff[IW-2:0], go_right};

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      j_in          = j_ff;
      code_in       = code_ff;
      slot_in       = slot_ff;
      inrange_in    = inrange_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_code_in   = rsp_code_ff;
      ram_we        = 1'b0;
      ram_waddr     = j_ff[AW-1:0];
      ram_wdata     = code_ff;
      ram_re        = 1'b0;
      ram_raddr     = j_next[AW-1:0];

      unique case (state_ff)
         bst_pkg::ST_CLEAR: begin
            // Sweep the RAM, one entry per cycle, writing the empty code.
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = bst_pkg::ST_IDLE;
            end
         end

         bst_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_op == bst_pkg::OP_READ) begin
                  slot_in    = req_slot;
                  inrange_in = slot_ext < SLOTS_IW;
                  ram_re     = 1'b1;
                  ram_raddr  = slot_ext[AW-1:0];
                  state_in   = bst_pkg::ST_READ;
               end else if (req_value == '0) begin
                  state_in = bst_pkg::ST_REJECT;
               end else begin
                  // Start the walk at the root.
                  code_in   = {req_value, 1'b0};
                  j_in      = ROOT_IDX;
                  ram_re    = 1'b1;
                  ram_raddr = ROOT_IDX[AW-1:0];
                  state_in  = bst_pkg::ST_WALK;
               end
            end
         end

         bst_pkg::ST_READ: begin
            // Hold the read data until the result register frees up.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = bst_pkg::STATUS_READ;
               rsp_slot_in   = slot_ff;
               rsp_code_in   = inrange_ff ? $signed(ram_rdata) : '0;
               state_in      = bst_pkg::ST_IDLE;
            end
         end

         bst_pkg::ST_WALK: begin
            if (out_free) begin
               if (ram_rdata == '0) begin
                  // Empty slot found: store the code here.
                  ram_we        = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bst_pkg::STATUS_INSERTED;
                  rsp_slot_in   = j_ff[bst_pkg::SLOT_W-1:0];
                  rsp_code_in   = code_ff;
                  state_in      = bst_pkg::ST_IDLE;
               end else if (j_next >= SLOTS_IW) begin
                  // Walk fell off the bottom of the table: drop the insert.
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bst_pkg::STATUS_FULL;
                  rsp_slot_in   = '0;
                  rsp_code_in   = '0;
                  state_in      = bst_pkg::ST_IDLE;
               end else begin
                  // Advance one level and fetch the child.
                  j_in   = j_next;
                  ram_re = 1'b1;
               end
            end
         end

         bst_pkg::ST_REJECT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = bst_pkg::STATUS_ZERO;
               rsp_slot_in   = '0;
               rsp_code_in   = '0;
               state_in      = bst_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bst_pkg::ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bst_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset needed.
   always_ff @(posedge clock) begin
      j_ff          <= j_in;
      code_ff       <= code_in;
      slot_ff       <= slot_in;
      inrange_ff    <= inrange_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_code_ff   <= rsp_code_in;
   end

   assign req_ready         = state_ff == bst_pkg::ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_placed_slot   = rsp_slot_ff;
   assign rsp_stored_code   = rsp_code_ff;
   // Stored codes are always even, so halving is an exact shift.
   assign rsp_decoded_value = rsp_code_ff[bst_pkg::CODE_W-1:1];
   assign rsp_occupied      = rsp_code_ff != '0;

   // RAM writes come only from the clearing pass or the end of a walk.
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == bst_pkg::ST_CLEAR || state_ff == bst_pkg::ST_WALK))
      else $error("tree RAM written outside clear or walk");

   // The walk index never leaves the table.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bst_pkg::ST_WALK) |-> (j_ff < SLOTS_IW && j_ff != '0))
      else $error("walk index outside table");

   // An insert result always reports an occupied slot.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bst_pkg::STATUS_INSERTED) |-> rsp_occupied)
      else $error("insert result reports empty slot");

   // Full and reject results carry no slot and no code.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == bst_pkg::STATUS_FULL ||
                     rsp_status == bst_pkg::STATUS_ZERO))
      |-> (rsp_placed_slot == '0 && !rsp_occupied))
      else $error("failed insert carries slot or code");

endmodule

`default_nettype wire
